[sv/clts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clts_pkg
// Types, sizes and codes shared by the colour life torus engine and its
// channel interfaces.
// ----------------------------------------------------------------------------
package clts_pkg;

	// Field widths of the request and result items
	localparam int COL_W    = 6;
	localparam int ROW_W    = 6;
	localparam int SIZE_W   = 7;
	localparam int COLOUR_W = 8;
	localparam int GEN_W    = 16;
	localparam int CFG_IDX_W = 1;

	// Grid store: stride is always the full width
	localparam int MAX_COLS  = 2 ** COL_W;
	localparam int MAX_ROWS  = 2 ** ROW_W;
	localparam int CELLS     = MAX_COLS * MAX_ROWS;
	localparam int MEM_AW    = 1 + ROW_W + COL_W;
	localparam int MEM_DEPTH = 2 * CELLS;

	// Neighbour sums and divide-by-three through a reciprocal
	localparam int SUM_W       = 11;
	localparam int RECIP_W     = 12;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 13;
	localparam logic [RECIP_W-1:0] RECIP3 = 12'd2731;

	localparam logic [COLOUR_W-1:0] COLOUR_MAX = 8'hFF;
	localparam logic [3:0] ADJ_KEEP = 4'd2;
	localparam logic [3:0] ADJ_BORN = 4'd3;
	localparam logic [3:0] ADJ_MAX  = 4'd8;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_ADVANCE = 2'd1,
		REQ_READ    = 2'd2
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLS = 1'b0,
		CFG_ROWS = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [COL_W-1:0]    col;
		logic [ROW_W-1:0]    row;
		logic                alive_in;
		logic [COLOUR_W-1:0] red_in;
		logic [COLOUR_W-1:0] green_in;
		logic [COLOUR_W-1:0] blue_in;
	} req_t;

	typedef struct packed {
		logic                alive_out;
		logic [COLOUR_W-1:0] red_out;
		logic [COLOUR_W-1:0] green_out;
		logic [COLOUR_W-1:0] blue_out;
		logic [GEN_W-1:0]    generation_count;
	} rsp_t;

	typedef struct packed {
		logic                alive;
		logic [COLOUR_W-1:0] red;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] blue;
	} cell_t;

endpackage

[sv/clts_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clts channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface clts_req_if import clts_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface clts_rsp_if import clts_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface clts_cfg_if import clts_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIZE_W-1:0]    data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[sv/colour_life_torus_step_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colour_life_torus_step_core
// Coloured life engine on a wrapping grid with write, read and advance requests.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per transfer (write cell, read cell, advance one
//          generation); any other type code returns a zero cell.
//   rsp  : exactly one result per request, carrying the read cell (zero for
//          other requests) and the generation count after the request.
//   cfg  : register writes (index 0 width, index 1 height), always ready;
//          write only while no request is in flight.
// Service, from the request transfer to a valid result:
//   write / other : result registered at the transfer, read : memory read
//                   register, then the result register,
//   advance       : per cell, 8 neighbour reads plus the cell's own read on
//                   the single memory read port, one accumulate, two passes
//                   through the shared divide-by-three multiplier, one write.
// One request is in service at a time; writes can transfer every cycle while
// results are taken. A new request transfers once the last result is taken,
// or with it. Reset: a clearing pass writes all 8192 entries of both grid
// banks with req held not ready; cfg writes are taken throughout.
// A stalled rsp holds its result; req stays not ready until it is taken.
// ----------------------------------------------------------------------------
module colour_life_torus_step_core import clts_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	clts_cfg_if.sink    cfg,
	clts_req_if.sink    req,
	clts_rsp_if.source  rsp
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_WAIT,
		ST_ADV_RD,
		ST_ADV_ACC,
		ST_ADV_DIV_R,
		ST_ADV_DIV_B,
		ST_ADV_WR
	} state_t;

	state_t              state_q;
	logic [MEM_AW-1:0]   clr_addr_q;
	logic [SIZE_W-1:0]   cols_q;
	logic [SIZE_W-1:0]   rows_q;
	logic                front_q;
	logic [GEN_W-1:0]    gen_q;

	// Advance walk: current cell and neighbour tap
	logic [COL_W-1:0]    x_q;
	logic [ROW_W-1:0]    y_q;
	logic [1:0]          dx_q;
	logic [1:0]          dy_q;
	logic                tap_valid_s1;
	logic                tap_center_s1;
	logic [3:0]          adj_q;
	logic [SUM_W-1:0]    rs_q;
	logic [SUM_W-1:0]    bs_q;
	cell_t               self_q;
	logic [COLOUR_W-1:0] red_q;
	logic [COLOUR_W-1:0] blue_q;

	logic                rd_inside_q;
	logic                out_valid_q;
	rsp_t                out_q;

	// Grid store: both banks in one array, bank bit on top of the address
	cell_t               grid_mem [0:MEM_DEPTH-1];
	cell_t               rdata_s1;

	logic [SIZE_W-1:0]   w_eff;
	logic [SIZE_W-1:0]   h_eff;
	logic [COL_W-1:0]    x_max;
	logic [ROW_W-1:0]    y_max;
	logic [COL_W-1:0]    nx;
	logic [ROW_W-1:0]    ny;
	logic                req_in_grid;
	logic                in_ready;
	logic                req_fire;
	logic                wr_en;
	logic [MEM_AW-1:0]   wr_addr;
	cell_t               wr_data;
	logic [MEM_AW-1:0]   rd_addr;
	cell_t               new_cell;
	logic [SUM_W-1:0]    mul_in;
	logic [PROD_W-1:0]   mul_prod;
	logic [COLOUR_W-1:0] quot;
	logic                out_load;
	rsp_t                out_next;

	// Clamp the configured size into 1..MAX
	always_comb begin
		priority if (cols_q == '0) begin
			w_eff = SIZE_W'(1);
		end else if (cols_q > SIZE_W'(MAX_COLS)) begin
			w_eff = SIZE_W'(MAX_COLS);
		end else begin
			w_eff = cols_q;
		end
		priority if (rows_q == '0) begin
			h_eff = SIZE_W'(1);
		end else if (rows_q > SIZE_W'(MAX_ROWS)) begin
			h_eff = SIZE_W'(MAX_ROWS);
		end else begin
			h_eff = rows_q;
		end
	end

	assign x_max  = COL_W'(w_eff - SIZE_W'(1));
	assign y_max  = ROW_W'(h_eff - SIZE_W'(1));
	assign req_in_grid = ({1'b0, req.data.col} < w_eff) && ({1'b0, req.data.row} < h_eff);

	// Neighbour position with wrap; tiny grids wrap onto the cell itself
	always_comb begin
		unique case (dx_q)
			2'd0:    nx = (x_q == '0) ? x_max : COL_W'(x_q - COL_W'(1));
			2'd1:    nx = x_q;
			default: nx = (x_q == x_max) ? '0 : COL_W'(x_q + COL_W'(1));
		endcase
		unique case (dy_q)
			2'd0:    ny = (y_q == '0) ? y_max : ROW_W'(y_q - ROW_W'(1));
			2'd1:    ny = y_q;
			default: ny = (y_q == y_max) ? '0 : ROW_W'(y_q + ROW_W'(1));
		endcase
	end

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign req_fire = req.valid && in_ready;

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Shared divide-by-three: reciprocal multiply, exact while the quotient fits a colour (sums below 768)
	assign mul_in   = (state_q == ST_ADV_DIV_B) ? bs_q : rs_q;
	assign mul_prod = PROD_W'(mul_in) * PROD_W'(RECIP3);
	assign quot     = COLOUR_W'(mul_prod >> RECIP_SHIFT);

	// Next value of the current cell
	always_comb begin
		priority if (adj_q == ADJ_KEEP) begin
			new_cell = self_q;
		end else if (adj_q == ADJ_BORN) begin
			new_cell.alive = 1'b1;
			new_cell.red   = red_q;
			new_cell.green = COLOUR_W'(COLOUR_MAX - red_q - blue_q);
			new_cell.blue  = blue_q;
		end else begin
			new_cell.alive = 1'b0;
			new_cell.red   = COLOUR_MAX;
			new_cell.green = '0;
			new_cell.blue  = COLOUR_MAX;
		end
	end

	// Result select: read data, end of an advance, or a zero cell right away
	always_comb begin
		out_load                  = 1'b0;
		out_next                  = '0;
		out_next.generation_count = gen_q;
		priority if (state_q == ST_READ_WAIT) begin
			out_load = 1'b1;
			if (rd_inside_q) begin
				out_next.alive_out = rdata_s1.alive;
				out_next.red_out   = rdata_s1.red;
				out_next.green_out = rdata_s1.green;
				out_next.blue_out  = rdata_s1.blue;
			end
		end else if (state_q == ST_ADV_WR && x_q == x_max && y_q == y_max) begin
			out_load                  = 1'b1;
			out_next.generation_count = GEN_W'(gen_q + GEN_W'(1));
		end else if (req_fire && req.data.req_type != REQ_ADVANCE &&
				req.data.req_type != REQ_READ) begin
			out_load = 1'b1;
		end else begin
			out_load = 1'b0;
		end
	end

	// Memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		priority if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
		end else if (req_fire && req.data.req_type == REQ_WRITE && req_in_grid) begin
			wr_en         = 1'b1;
			wr_addr       = {front_q, req.data.row, req.data.col};
			wr_data.alive = req.data.alive_in;
			wr_data.red   = req.data.red_in;
			wr_data.green = req.data.green_in;
			wr_data.blue  = req.data.blue_in;
		end else if (state_q == ST_ADV_WR) begin
			wr_en   = 1'b1;
			wr_addr = {~front_q, y_q, x_q};
			wr_data = new_cell;
		end else begin
			wr_en = 1'b0;
		end
	end

	assign rd_addr = (state_q == ST_ADV_RD) ? {front_q, ny, nx}
	                                        : {front_q, req.data.row, req.data.col};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grid_mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= grid_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			cols_q        <= SIZE_W'(MAX_COLS);
			rows_q        <= SIZE_W'(MAX_ROWS);
			front_q       <= 1'b0;
			gen_q         <= '0;
			x_q           <= '0;
			y_q           <= '0;
			dx_q          <= '0;
			dy_q          <= '0;
			tap_valid_s1  <= 1'b0;
			tap_center_s1 <= 1'b0;
			adj_q         <= '0;
			rs_q          <= '0;
			bs_q          <= '0;
			self_q        <= '0;
			red_q         <= '0;
			blue_q        <= '0;
			rd_inside_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg_index_t'(cfg.index))
					CFG_COLS: cols_q <= cfg.data;
					CFG_ROWS: rows_q <= cfg.data;
				endcase
			end

			// Load a new result, else drop the one just transferred
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= out_next;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// Accumulate the live tap read in the previous cycle; the centre tap is kept as the cell itself
			tap_valid_s1  <= (state_q == ST_ADV_RD);
			tap_center_s1 <= (dx_q == 2'd1) && (dy_q == 2'd1);
			if (tap_valid_s1) begin
				if (tap_center_s1) begin
					self_q <= rdata_s1;
				end else if (rdata_s1.alive) begin
					adj_q <= 4'(adj_q + 4'd1);
					rs_q  <= SUM_W'(rs_q + SUM_W'(rdata_s1.red));
					bs_q  <= SUM_W'(bs_q + SUM_W'(rdata_s1.blue));
				end
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= MEM_AW'(clr_addr_q + MEM_AW'(1));
					if (&clr_addr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						unique case (req_kind_t'(req.data.req_type))
							REQ_ADVANCE: begin
								state_q <= ST_ADV_RD;
								x_q     <= '0;
								y_q     <= '0;
								dx_q    <= '0;
								dy_q    <= '0;
								adj_q   <= '0;
								rs_q    <= '0;
								bs_q    <= '0;
							end
							REQ_READ: begin
								state_q     <= ST_READ_WAIT;
								rd_inside_q <= req_in_grid;
							end
							default: begin
								// Write or unused code: zero cell loads right away
							end
						endcase
					end
				end
				ST_READ_WAIT: begin
					state_q <= ST_IDLE;
				end
				ST_ADV_RD: begin
					if (dx_q == 2'd2) begin
						dx_q <= '0;
						if (dy_q == 2'd2) begin
							dy_q    <= '0;
							state_q <= ST_ADV_ACC;
						end else begin
							dy_q <= 2'(dy_q + 2'd1);
						end
					end else begin
						dx_q <= 2'(dx_q + 2'd1);
					end
				end
				ST_ADV_ACC: begin
					state_q <= ST_ADV_DIV_R;
				end
				ST_ADV_DIV_R: begin
					red_q   <= quot;
					state_q <= ST_ADV_DIV_B;
				end
				ST_ADV_DIV_B: begin
					blue_q  <= quot;
					state_q <= ST_ADV_WR;
				end
				ST_ADV_WR: begin
					adj_q <= '0;
					rs_q  <= '0;
					bs_q  <= '0;
					if (x_q == x_max) begin
						x_q <= '0;
						if (y_q == y_max) begin
							// Last cell: swap banks; the result loads above
							y_q     <= '0;
							front_q <= ~front_q;
							gen_q   <= GEN_W'(gen_q + GEN_W'(1));
							state_q <= ST_IDLE;
						end else begin
							y_q     <= ROW_W'(y_q + ROW_W'(1));
							state_q <= ST_ADV_RD;
						end
					end else begin
						x_q     <= COL_W'(x_q + COL_W'(1));
						state_q <= ST_ADV_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_clear_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !req.ready)
		else $error("request taken during clearing pass");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.data.req_type == REQ_READ) |-> ##2 out_valid_q)
		else $error("read result not ready two cycles after transfer");

	a_adv_dst_bank: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADV_WR |-> wr_en && (wr_addr[MEM_AW-1] != front_q))
		else $error("advance writes into the source bank");

	a_adv_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV_WR && x_q == x_max && y_q == y_max) |=>
			out_valid_q && (front_q != $past(front_q)) &&
			(rsp.data.generation_count == gen_q))
		else $error("advance end did not swap banks and report");

	a_adj_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADV_DIV_R |-> adj_q <= ADJ_MAX)
		else $error("neighbour count out of range");
`endif

endmodule

[dv/tb_colour_life_torus_step_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_colour_life_torus_step_core
// Self-checking bench for the coloured life engine. A cycle-free model of the
// grid predicts every result: cell write, cell read, whole-grid advance on the
// torus, and the generation count. Directed cases cover field extremes, size
// clamping, out-of-grid addresses, torus-edge wrap, the unused request code and
// a long result stall. Random rounds then resize the grid, seed it, advance it
// and read it back under random idle bursts on both sides and a quiet tail.
// ----------------------------------------------------------------------------
module tb_colour_life_torus_step_core;
	import clts_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 250;
	localparam int RANDOM_ITEMS  = 100;
	localparam int QUIET_TAIL    = 30;
	// Request code that the block does not define: must leave all state alone
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// Neighbour counts that keep a cell or give birth to one
	localparam int KEEP_COUNT  = 2;
	localparam int BIRTH_COUNT = 3;

	logic clk;
	logic arst_n;

	clts_cfg_if cfg_ch();
	clts_req_if req_ch();
	clts_rsp_if rsp_ch();

	colour_life_torus_step_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Model of the grid: two banks, one shown, and the generation count
	cell_t            board [2][CELLS];
	logic             shown_bank;
	logic [GEN_W-1:0] gens_done;
	logic [SIZE_W-1:0] width_reg;
	logic [SIZE_W-1:0] height_reg;

	// Results owed by the block, oldest first
	rsp_t expected_rsp_q [$];
	rsp_t want;
	rsp_t got;

	int err_count  = 0;
	int sent_count = 0;
	int cycle_count;
	// Random idle bursts on both sides while set
	bit bursts_on;
	// Long result stall, counted down by the receiver
	int hold_left;

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Grid model
	// ------------------------------------------------------------------------
	function automatic void clear_board();
		for (int i = 0; i < CELLS; i++) begin
			board[0][i] = '0;
			board[1][i] = '0;
		end
		shown_bank = 1'b0;
		gens_done  = '0;
		width_reg  = SIZE_W'(MAX_COLS);
		height_reg = SIZE_W'(MAX_ROWS);
	endfunction

	// Zero counts as one, anything past the store counts as the store size
	function automatic int used_size(logic [SIZE_W-1:0] v, int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return int'(v);
	endfunction

	// Build the next generation into the hidden bank, then flip banks
	function automatic void advance_board();
		int    w;
		int    h;
		int    x;
		int    y;
		int    dx;
		int    dy;
		int    n;
		int    m;
		int    adj;
		int    rsum;
		int    bsum;
		logic  src;
		cell_t nb;
		cell_t nxt;
		w   = used_size(width_reg, MAX_COLS);
		h   = used_size(height_reg, MAX_ROWS);
		src = shown_bank;
		for (y = 0; y < h; y++) begin
			for (x = 0; x < w; x++) begin
				adj  = 0;
				rsum = 0;
				bsum = 0;
				// Wrap modulo the size in use: on tiny grids one cell may count
				// several times, the cell itself included
				for (dy = 0; dy < 3; dy++) begin
					n = (y + h + dy - 1) % h;
					for (dx = 0; dx < 3; dx++) begin
						if (dx == 1 && dy == 1)
							continue;
						m  = (x + w + dx - 1) % w;
						nb = board[src][n * MAX_COLS + m];
						if (nb.alive) begin
							adj++;
							rsum += nb.red;
							bsum += nb.blue;
						end
					end
				end
				if (adj == KEEP_COUNT) begin
					nxt = board[src][y * MAX_COLS + x];
				end else if (adj == BIRTH_COUNT) begin
					// Newborn takes the mean red and blue of its three parents
					nxt.alive = 1'b1;
					nxt.red   = COLOUR_W'(rsum / BIRTH_COUNT);
					nxt.blue  = COLOUR_W'(bsum / BIRTH_COUNT);
					nxt.green = COLOUR_MAX - nxt.red - nxt.blue;
				end else begin
					nxt = '{alive: 1'b0, red: COLOUR_MAX, green: '0, blue: COLOUR_MAX};
				end
				board[~src][y * MAX_COLS + x] = nxt;
			end
		end
		shown_bank = ~src;
		gens_done  = gens_done + 1'b1;
	endfunction

	// Apply one request to the model and return the result it owes
	function automatic rsp_t predict_result(req_t r);
		int    w;
		int    h;
		int    addr;
		bit    in_grid;
		cell_t c;
		w       = used_size(width_reg, MAX_COLS);
		h       = used_size(height_reg, MAX_ROWS);
		in_grid = (r.col < w) && (r.row < h);
		addr    = r.row * MAX_COLS + r.col;
		c       = '0;
		case (r.req_type)
			REQ_WRITE: begin
				if (in_grid)
					board[shown_bank][addr] = '{r.alive_in, r.red_in, r.green_in, r.blue_in};
			end
			REQ_ADVANCE: begin
				advance_board();
			end
			REQ_READ: begin
				if (in_grid)
					c = board[shown_bank][addr];
			end
			default: begin
			end
		endcase
		return '{c.alive, c.red, c.green, c.blue, gens_done};
	endfunction

	// ------------------------------------------------------------------------
	// Request builders
	// ------------------------------------------------------------------------
	function automatic req_t cell_req(logic [1:0] kind, int c, int r, logic alive,
			logic [COLOUR_W-1:0] red, logic [COLOUR_W-1:0] green,
			logic [COLOUR_W-1:0] blue);
		req_t q;
		q.req_type = kind;
		q.col      = COL_W'(c);
		q.row      = ROW_W'(r);
		q.alive_in = alive;
		q.red_in   = red;
		q.green_in = green;
		q.blue_in  = blue;
		return q;
	endfunction

	// Every field random, address over the whole 6-bit range
	function automatic req_t any_req(logic [1:0] kind);
		return cell_req(kind, $urandom_range(0, 63), $urandom_range(0, 63),
			1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endfunction

	// Mostly inside the grid; a few land outside and must be ignored
	function automatic req_t grid_req(logic [1:0] kind, int w, int h);
		req_t q;
		q = any_req(kind);
		if ($urandom_range(0, 9) != 0) begin
			q.col = COL_W'($urandom_range(0, w - 1));
			q.row = ROW_W'($urandom_range(0, h - 1));
		end
		// Lean toward live cells so that births and survivals happen
		q.alive_in = ($urandom_range(0, 4) < 3);
		return q;
	endfunction

	// ------------------------------------------------------------------------
	// Request driver: change at the falling edge, transfer at the rising edge
	// ------------------------------------------------------------------------
	task automatic send_req(req_t r);
		int gap;
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.data  = r;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		// Transfer taken: the model moves in the same order as the block
		expected_rsp_q.push_back(predict_result(r));
		sent_count++;
	endtask

	// Drop valid and wait until every owed result has come back
	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (expected_rsp_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [SIZE_W-1:0] v);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = v;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		if (idx == CFG_COLS)
			width_reg = v;
		else
			height_reg = v;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Resize only with nothing in flight; every request owes a result, so an
	// empty queue means the block is idle
	task automatic set_size(logic [SIZE_W-1:0] cols, logic [SIZE_W-1:0] rows);
		drain();
		write_reg(CFG_COLS, cols);
		write_reg(CFG_ROWS, rows);
	endtask

	// ------------------------------------------------------------------------
	// Result receiver: random stalls, plus the long hold when asked
	// ------------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else if (bursts_on && $urandom_range(0, 4) == 0) begin
				stall_left   = $urandom_range(1, 6) - 1;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker: each transfer against the oldest expectation
	// ------------------------------------------------------------------------
	task automatic check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.data;
			if (expected_rsp_q.size() == 0) begin
				$error("result transfer with nothing owed");
				err_count++;
			end else begin
				want = expected_rsp_q.pop_front();
				check_field("alive_out", want.alive_out, got.alive_out);
				check_field("red_out", want.red_out, got.red_out);
				check_field("green_out", want.green_out, got.green_out);
				check_field("blue_out", want.blue_out, got.blue_out);
				check_field("generation_count", want.generation_count,
					got.generation_count);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_colour_life_torus_step_core: errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Fresh store reads back zero; the unused code returns a zero cell
	task automatic test_reset_state();
		bursts_on = 1'b0;
		send_req(cell_req(REQ_READ, 0, 0, 1'b0, '0, '0, '0));
		send_req(cell_req(REQ_READ, 63, 63, 1'b1, '1, '1, '1));
		send_req(cell_req(REQ_UNUSED, 17, 42, 1'b1, '1, '1, '1));
		drain();
	endtask

	// Corners of the address space with all-ones, all-zeros and checkered data
	task automatic test_write_read_extremes();
		bursts_on = 1'b1;
		send_req(cell_req(REQ_WRITE, 63, 63, 1'b1, 8'hFF, 8'hFF, 8'hFF));
		send_req(cell_req(REQ_WRITE, 0, 0, 1'b0, 8'h00, 8'h00, 8'h00));
		send_req(cell_req(REQ_WRITE, 0, 63, 1'b1, 8'hA5, 8'h5A, 8'hC3));
		send_req(cell_req(REQ_READ, 63, 63, 1'b0, 8'h00, 8'h00, 8'h00));
		send_req(cell_req(REQ_READ, 0, 63, 1'b0, 8'h5A, 8'hA5, 8'h3C));
		send_req(cell_req(REQ_READ, 0, 0, 1'b1, 8'hFF, 8'hFF, 8'hFF));
		drain();
	endtask

	// One advance over the full 64 x 64 grid with a blinker straddling the wrap
	task automatic test_full_grid_advance();
		send_req(cell_req(REQ_WRITE, 63, 0, 1'b1, 8'd200, 8'd10, 8'd30));
		send_req(cell_req(REQ_WRITE, 0, 0, 1'b1, 8'd100, 8'd20, 8'd60));
		send_req(cell_req(REQ_WRITE, 1, 0, 1'b1, 8'd7, 8'd30, 8'd255));
		send_req(cell_req(REQ_ADVANCE, 0, 0, 1'b0, '0, '0, '0));
		send_req(cell_req(REQ_READ, 0, 63, 1'b0, '0, '0, '0));
		send_req(cell_req(REQ_READ, 0, 1, 1'b0, '0, '0, '0));
		send_req(cell_req(REQ_READ, 63, 0, 1'b0, '0, '0, '0));
		send_req(cell_req(REQ_READ, 5, 5, 1'b0, '0, '0, '0));
		drain();
	endtask

	// Size clamping, out-of-grid addresses and a cell that is its own neighbour
	task automatic test_small_torus();
		// Zero clamps to a single cell: its eight neighbours are all itself
		set_size('0, '0);
		send_req(cell_req(REQ_WRITE, 0, 0, 1'b1, 8'd90, 8'd1, 8'd33));
		send_req(cell_req(REQ_WRITE, 1, 0, 1'b1, 8'd1, 8'd2, 8'd3));
		send_req(cell_req(REQ_READ, 1, 0, 1'b0, '0, '0, '0));
		send_req(cell_req(REQ_ADVANCE, 0, 0, 1'b0, '0, '0, '0));
		send_req(cell_req(REQ_READ, 0, 0, 1'b0, '0, '0, '0));
		// Two wide, height past the store: clamps to 64 rows
		set_size(SIZE_W'(2), '1);
		send_req(cell_req(REQ_WRITE, 0, 5, 1'b1, 8'd40, 8'd50, 8'd60));
		send_req(cell_req(REQ_WRITE, 1, 5, 1'b1, 8'd70, 8'd80, 8'd90));
		send_req(cell_req(REQ_ADVANCE, 0, 0, 1'b0, '0, '0, '0));
		send_req(cell_req(REQ_READ, 0, 5, 1'b0, '0, '0, '0));
		drain();
	endtask

	// Hold results off for a long stretch while requests keep coming, so the
	// block fills and stalls its input; then pause until all results are back
	task automatic test_result_backpressure();
		set_size(SIZE_W'(4), SIZE_W'(4));
		bursts_on = 1'b0;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 10; i++)
			send_req(grid_req((i % 3 == 2) ? REQ_READ : REQ_WRITE, 4, 4));
		drain();
	endtask

	// Resize, seed, advance and read back in rounds; the tail runs without idling
	task automatic test_random_mix();
		int target;
		int w;
		int h;
		int pick;
		logic [SIZE_W-1:0] cols;
		logic [SIZE_W-1:0] rows;
		target = sent_count + RANDOM_ITEMS;
		while (sent_count < target) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: begin
					cols = SIZE_W'($urandom_range(0, 2));
					rows = SIZE_W'($urandom_range(1, 8));
				end
				1: begin
					cols = SIZE_W'($urandom_range(1, 3));
					rows = SIZE_W'($urandom_range(64, 127));
				end
				2: begin
					cols = SIZE_W'($urandom_range(64, 127));
					rows = SIZE_W'($urandom_range(0, 2));
				end
				default: begin
					cols = SIZE_W'($urandom_range(3, 8));
					rows = SIZE_W'($urandom_range(3, 8));
				end
			endcase
			set_size(cols, rows);
			bursts_on = (sent_count < target - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
			w = used_size(cols, MAX_COLS);
			h = used_size(rows, MAX_ROWS);
			// Seed the grid
			repeat ($urandom_range(3, 10))
				send_req(grid_req(REQ_WRITE, w, h));
			// Evolve and observe, with some noise mixed in
			repeat ($urandom_range(2, 6)) begin
				pick = $urandom_range(0, 9);
				if (pick < 3)
					send_req(any_req(REQ_ADVANCE));
				else if (pick < 7)
					send_req(grid_req(REQ_READ, w, h));
				else if (pick == 7)
					send_req(any_req(REQ_READ));
				else if (pick == 8)
					send_req(any_req(REQ_WRITE));
				else
					send_req(any_req(REQ_UNUSED));
			end
			send_req(grid_req(REQ_READ, w, h));
		end
		drain();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_COLS;
		cfg_ch.data  = '0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		bursts_on    = 1'b0;
		hold_left    = 0;
		clear_board();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The clearing pass after reset holds req not ready; send waits it out
		test_reset_state();
		test_write_read_extremes();
		test_full_grid_advance();
		test_small_torus();
		test_result_backpressure();
		test_random_mix();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_rsp_q.size() == 0)
			$display("tb_colour_life_torus_step_core: clean");
		else
			$display("tb_colour_life_torus_step_core: errors");
		$finish;
	end

endmodule
